[design/tcoqs_pkg.sv]
`default_nettype none
package tcoqs_pkg;

  localparam int BULK_DEPTH    = 8;
  localparam int CONTROL_DEPTH = 16;
  localparam int BULK_AW       = (BULK_DEPTH > 1) ? $clog2(BULK_DEPTH) : 1;
  localparam int CTRL_AW       = (CONTROL_DEPTH > 1) ? $clog2(CONTROL_DEPTH) : 1;
  localparam int BULK_CW       = $clog2(BULK_DEPTH + 1);
  localparam int CTRL_CW       = $clog2(CONTROL_DEPTH + 1);

  localparam logic [15:0] BULK_MIN_PAYLOAD = 16'd4;

  localparam logic [1:0] FUNC_ADMIT   = 2'd0;
  localparam logic [1:0] FUNC_LISTING = 2'd1;
  localparam logic [1:0] FUNC_LINKS   = 2'd2;
  localparam logic [1:0] FUNC_SELECT  = 2'd3;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_BULK    = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_PURGED   = 2'd2;

  localparam logic [1:0] SRC_OTHER = 2'd0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [15:0] frame_handle;
    logic [7:0]  destination_host;
    logic        destination_broadcast;
    logic [1:0]  source_kind;
    logic        usb_on;
    logic        tcp_on;
  } tcoqs_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  admission_status;
    logic [15:0] sent_frame_handle;
    logic [7:0]  sent_host;
    logic        sent_broadcast;
    logic        delay_next;
    logic [3:0]  pending_bulk;
    logic [4:0]  pending_control;
    logic        last;
  } tcoqs_out_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [7:0]  host;
    logic        bcast;
  } tcoqs_entry_t;

endpackage
`default_nettype wire

[design/tcoqs_ram.sv]
`default_nettype none
module tcoqs_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 25,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/two_class_output_queue_scheduler.sv]
// Two-class output queue scheduler: frame references wait in a bulk queue and a
// control queue, each held in a single-port-read synchronous RAM.
// Channels: in_valid/in_ready/in_data carry one operation (admit, admit listing,
// set link flags, select batch); out_valid/out_ready/out_data carry results;
// cfg_valid/cfg_ready/cfg_data write the bulk frame type code (always ready).
// An operation is taken only in idle; the next cycle executes it. Admit, listing
// and link operations give one result, registered at the end of that cycle, and
// no new operation is taken until that result is loaded into the result register.
// A select issues one queue RAM read per cycle and, after its first entry
// appears, gives one entry per cycle while the receiver does not stall. The
// RAM read port and the single result register set this pace. An empty select
// gives one result.
// The result register lets a new operation be accepted while the last result
// of the previous one still waits. When the receiver stalls, execution holds
// with the pending RAM read data kept until the result register frees up.
// Synchronous reset empties both queues, drops both links and clears the type
// code; queue RAM contents are not cleared and no clearing pass is needed.
`default_nettype none
module two_class_output_queue_scheduler (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcoqs_pkg::tcoqs_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tcoqs_pkg::tcoqs_out_t      out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_BRD  = 2'd2;
  localparam logic [1:0] S_CRD  = 2'd3;

  localparam int BAW = tcoqs_pkg::BULK_AW;
  localparam int CAW = tcoqs_pkg::CTRL_AW;
  localparam int BCW = tcoqs_pkg::BULK_CW;
  localparam int CCW = tcoqs_pkg::CTRL_CW;
  localparam int EW  = $bits(tcoqs_pkg::tcoqs_entry_t);

  logic [1:0]            state, state_next;
  tcoqs_pkg::tcoqs_in_t  item;
  logic [7:0]            bulk_data_type;
  logic [BAW-1:0]        bulk_head, bulk_head_next;
  logic [BCW-1:0]        bulk_count, bulk_count_next;
  logic [CAW-1:0]        ctrl_head, ctrl_head_next;
  logic [CCW-1:0]        ctrl_count, ctrl_count_next;
  logic                  usb_up, usb_up_next;
  logic                  tcp_up, tcp_up_next;
  logic                  sel_delay, sel_delay_next;
  logic                  out_load;
  tcoqs_pkg::tcoqs_out_t out_next;

  logic                  b_we, b_re, c_we, c_re;
  logic [EW-1:0]         b_rdata, c_rdata;
  tcoqs_pkg::tcoqs_entry_t ent, b_ent, c_ent;
  logic [BCW:0]          b_wsum;
  logic [CCW:0]          c_wsum;
  logic [BAW-1:0]        b_waddr, bulk_head_adv;
  logic [CAW-1:0]        c_waddr, ctrl_head_adv;
  logic                  out_free, links, is_bulk, b_full, c_full;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign ent.handle = item.frame_handle;
  assign ent.host   = item.destination_broadcast ? 8'd0 : item.destination_host;
  assign ent.bcast  = item.destination_broadcast;
  assign b_ent      = tcoqs_pkg::tcoqs_entry_t'(b_rdata);
  assign c_ent      = tcoqs_pkg::tcoqs_entry_t'(c_rdata);

  assign links   = usb_up || tcp_up;
  assign is_bulk = (item.frame_type == bulk_data_type) &&
                   (item.payload_length > tcoqs_pkg::BULK_MIN_PAYLOAD);
  assign b_full  = (bulk_count >= BCW'(tcoqs_pkg::BULK_DEPTH));
  assign c_full  = (ctrl_count >= CCW'(tcoqs_pkg::CONTROL_DEPTH));

  // tail slot, head plus count wrapped once
  assign b_wsum  = (BCW+1)'(bulk_head) + (BCW+1)'(bulk_count);
  assign c_wsum  = (CCW+1)'(ctrl_head) + (CCW+1)'(ctrl_count);
  assign b_waddr = (b_wsum >= (BCW+1)'(tcoqs_pkg::BULK_DEPTH)) ?
                   BAW'(b_wsum - (BCW+1)'(tcoqs_pkg::BULK_DEPTH)) : BAW'(b_wsum);
  assign c_waddr = (c_wsum >= (CCW+1)'(tcoqs_pkg::CONTROL_DEPTH)) ?
                   CAW'(c_wsum - (CCW+1)'(tcoqs_pkg::CONTROL_DEPTH)) : CAW'(c_wsum);

  assign bulk_head_adv = (bulk_head == BAW'(tcoqs_pkg::BULK_DEPTH - 1)) ? '0 :
                         bulk_head + BAW'(1);
  assign ctrl_head_adv = (ctrl_head == CAW'(tcoqs_pkg::CONTROL_DEPTH - 1)) ? '0 :
                         ctrl_head + CAW'(1);

  always_comb begin
    state_next      = state;
    bulk_head_next  = bulk_head;
    bulk_count_next = bulk_count;
    ctrl_head_next  = ctrl_head;
    ctrl_count_next = ctrl_count;
    usb_up_next     = usb_up;
    tcp_up_next     = tcp_up;
    sel_delay_next  = sel_delay;
    out_load        = 1'b0;
    out_next        = '0;
    b_we            = 1'b0;
    c_we            = 1'b0;
    b_re            = 1'b0;
    c_re            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item.func == tcoqs_pkg::FUNC_SELECT) begin
          priority if (bulk_count != '0) begin
            b_re            = 1'b1;
            bulk_head_next  = bulk_head_adv;
            bulk_count_next = bulk_count - BCW'(1);
            sel_delay_next  = 1'b1;
            state_next      = S_BRD;
          end else if (ctrl_count != '0) begin
            c_re            = 1'b1;
            ctrl_head_next  = ctrl_head_adv;
            ctrl_count_next = ctrl_count - CCW'(1);
            sel_delay_next  = 1'b0;
            state_next      = S_CRD;
          end else begin
            if (out_free) begin
              out_load             = 1'b1;
              out_next.result_kind = tcoqs_pkg::KIND_EMPTY;
              out_next.delay_next  = 1'b1;
              out_next.last        = 1'b1;
              state_next           = S_IDLE;
            end
          end
        end else if (out_free) begin
          out_load                  = 1'b1;
          out_next.result_kind      = tcoqs_pkg::KIND_STATUS;
          out_next.admission_status = tcoqs_pkg::STAT_ACCEPTED;
          out_next.last             = 1'b1;
          state_next                = S_IDLE;
          unique case (item.func)
            tcoqs_pkg::FUNC_ADMIT: begin
              priority if (is_bulk) begin
                if (b_full) begin
                  out_next.admission_status = tcoqs_pkg::STAT_DROPPED;
                end else begin
                  b_we            = 1'b1;
                  bulk_count_next = bulk_count + BCW'(1);
                end
              end else if (!links) begin
                out_next.admission_status = tcoqs_pkg::STAT_DROPPED;
              end else if (c_full) begin
                if (item.source_kind != tcoqs_pkg::SRC_OTHER) begin
                  ctrl_head_next            = '0;
                  ctrl_count_next           = '0;
                  out_next.admission_status = tcoqs_pkg::STAT_PURGED;
                end else begin
                  out_next.admission_status = tcoqs_pkg::STAT_DROPPED;
                end
              end else begin
                c_we            = 1'b1;
                ctrl_count_next = ctrl_count + CCW'(1);
              end
            end
            tcoqs_pkg::FUNC_LISTING: begin
              if (!links || c_full) begin
                out_next.admission_status = tcoqs_pkg::STAT_DROPPED;
              end else begin
                c_we            = 1'b1;
                ctrl_count_next = ctrl_count + CCW'(1);
              end
            end
            tcoqs_pkg::FUNC_LINKS: begin
              usb_up_next = item.usb_on;
              tcp_up_next = item.tcp_on;
              if (!item.usb_on && !item.tcp_on) begin
                ctrl_head_next  = '0;
                ctrl_count_next = '0;
              end
            end
            tcoqs_pkg::FUNC_SELECT: begin
            end
          endcase
          out_next.pending_bulk    = 4'(bulk_count_next);
          out_next.pending_control = 5'(ctrl_count_next);
        end
      end
      S_BRD: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_next.result_kind       = tcoqs_pkg::KIND_BULK;
          out_next.sent_frame_handle = b_ent.handle;
          out_next.sent_host         = b_ent.host;
          out_next.sent_broadcast    = b_ent.bcast;
          out_next.delay_next        = sel_delay;
          out_next.pending_bulk      = 4'(bulk_count);
          out_next.last              = (ctrl_count == '0);
          if (ctrl_count != '0) begin
            c_re            = 1'b1;
            ctrl_head_next  = ctrl_head_adv;
            ctrl_count_next = ctrl_count - CCW'(1);
            state_next      = S_CRD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CRD: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_next.result_kind       = tcoqs_pkg::KIND_CONTROL;
          out_next.sent_frame_handle = c_ent.handle;
          out_next.sent_host         = c_ent.host;
          out_next.sent_broadcast    = c_ent.bcast;
          out_next.delay_next        = sel_delay;
          out_next.pending_bulk      = 4'(bulk_count);
          out_next.last              = (ctrl_count == '0);
          if (ctrl_count != '0) begin
            c_re            = 1'b1;
            ctrl_head_next  = ctrl_head_adv;
            ctrl_count_next = ctrl_count - CCW'(1);
          end else begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bulk_head      <= '0;
      bulk_count     <= '0;
      ctrl_head      <= '0;
      ctrl_count     <= '0;
      usb_up         <= 1'b0;
      tcp_up         <= 1'b0;
      sel_delay      <= 1'b0;
      out_valid      <= 1'b0;
      bulk_data_type <= 8'd0;
    end else begin
      state      <= state_next;
      bulk_head  <= bulk_head_next;
      bulk_count <= bulk_count_next;
      ctrl_head  <= ctrl_head_next;
      ctrl_count <= ctrl_count_next;
      usb_up     <= usb_up_next;
      tcp_up     <= tcp_up_next;
      sel_delay  <= sel_delay_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        bulk_data_type <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  tcoqs_ram #(
    .DEPTH (tcoqs_pkg::BULK_DEPTH),
    .WIDTH (EW)
  ) u_bulk_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (EW'(ent)),
    .rd_en   (b_re),
    .rd_addr (bulk_head),
    .rd_data (b_rdata)
  );

  tcoqs_ram #(
    .DEPTH (tcoqs_pkg::CONTROL_DEPTH),
    .WIDTH (EW)
  ) u_ctrl_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (EW'(ent)),
    .rd_en   (c_re),
    .rd_addr (ctrl_head),
    .rd_data (c_rdata)
  );

  a_bulk_bound: assert property (@(posedge clk) disable iff (rst)
    bulk_count <= BCW'(tcoqs_pkg::BULK_DEPTH))
    else $error("bulk occupancy above depth");

  a_ctrl_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl_count <= CCW'(tcoqs_pkg::CONTROL_DEPTH))
    else $error("control occupancy above depth");

  a_batch_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside a select batch");

  a_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_data.last)
    else $error("new transaction taken before batch finished");

  a_ctrl_drained: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == tcoqs_pkg::KIND_CONTROL
      |-> out_data.pending_control == 5'd0)
    else $error("control entry reports pending control entries");

endmodule
`default_nettype wire
